[rtl/core/optb_pkg.sv]
// ----------------------------------------------------------------------------
// optb_pkg
// Shared types and codes for the one-shot / periodic timer bank.
// ----------------------------------------------------------------------------
package optb_pkg;

	localparam int BANK_SLOTS = 4;
	localparam int DELAY_W    = 32;
	localparam int ELAPSED_W  = 33;
	localparam int CFG_IDX_W  = 3;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	// item kinds
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_START   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_RUNNING = 2'd1;
	localparam logic [1:0] ERR_NODELAY = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONESHOT = 3'd4;

	typedef struct packed {
		logic tick;
		logic start;
		logic restart;
	} lane_cmd_t;

endpackage

[rtl/core/optb_lane.sv]
// ----------------------------------------------------------------------------
// optb_lane
// One timer: delay register, running flag and elapsed count.
// ----------------------------------------------------------------------------
module optb_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  optb_pkg::lane_cmd_t            cmd,
	input  logic                           cfg_wr,
	input  logic [optb_pkg::DELAY_W-1:0]   cfg_data,
	input  logic                           oneshot,
	output logic                           expired,
	output logic [1:0]                     err
);

	logic [optb_pkg::DELAY_W-1:0]   delay_q;
	logic                           running_q;
	logic [optb_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [optb_pkg::ELAPSED_W-1:0] elapsed_inc;
	logic                           hit;
	logic                           go;

	always_comb begin
		if (elapsed_q == optb_pkg::ELAPSED_MAX) begin
			elapsed_inc = elapsed_q;
		end else begin
			elapsed_inc = elapsed_q + {{(optb_pkg::ELAPSED_W-1){1'b0}}, 1'b1};
		end
	end

	assign hit     = running_q && (elapsed_inc > {1'b0, delay_q});
	assign expired = cmd.tick && hit;

	always_comb begin
		err = optb_pkg::ERR_NONE;
		if (cmd.start || cmd.restart) begin
			if (delay_q == '0) begin
				err = optb_pkg::ERR_NODELAY;
			end else if (running_q && cmd.start) begin
				err = optb_pkg::ERR_RUNNING;
			end
		end
	end

	assign go = (cmd.start || cmd.restart) && (err == optb_pkg::ERR_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
		end else if (cfg_wr) begin
			delay_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			elapsed_q <= '0;
		end else if (go) begin
			running_q <= 1'b1;
			elapsed_q <= '0;
		end else if (cmd.tick && running_q) begin
			if (hit) begin
				elapsed_q <= '0;
				running_q <= !oneshot;
			end else begin
				elapsed_q <= elapsed_inc;
			end
		end
	end

endmodule

[rtl/core/oneshot_periodic_timer_bank_core.sv]
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_bank_core
// Bank of millisecond timers with per-timer delay and one-shot/periodic mode.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, kind, timer_index): each item is a
//    1 ms tick, a start or a restart of one timer.
//  - Output channel (out_valid/out_ready, expired_mask, error_code): exactly
//    one result item per input item, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): indexes 0..3
//    are the timer delays, index 4 the one-shot mask. Always ready; write
//    only while the bank is idle.
//  - Flow: an accepted item is held in the stage register, and its result is
//    then registered in the result register. Throughput is one item per cycle
//    while out_ready holds no stall, set by the single stage register plus
//    result register; all timers update in parallel.
//  - Reset: all timers stopped, counts and delays zero, one-shot mask all
//    ones, both channels empty.
//  - Stall: the result register holds while out_ready is low; one more item
//    can be taken into the stage register, then in_ready drops.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank_core #(
	parameter int NUM_TIMERS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       kind,
	input  logic [1:0]                       timer_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [3:0]                       expired_mask,
	output logic [1:0]                       error_code,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [optb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [optb_pkg::DELAY_W-1:0]     cfg_data
);

	logic                             valid_s1;
	logic [1:0]                       kind_s1;
	logic [1:0]                       idx_s1;
	logic                             adv;
	logic [3:0]                       oneshot_q;
	logic                             out_valid_q;
	logic [3:0]                       expired_q;
	logic [1:0]                       err_q;
	logic [optb_pkg::BANK_SLOTS-1:0]  exp_vec;
	logic [1:0]                       err_vec [optb_pkg::BANK_SLOTS];
	logic [1:0]                       err_sel;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			idx_s1  <= timer_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oneshot_q <= 4'hF;
		end else if (cfg_valid && cfg_index == optb_pkg::REG_ONESHOT) begin
			oneshot_q <= cfg_data[3:0];
		end
	end

	for (genvar g = 0; g < optb_pkg::BANK_SLOTS; g++) begin : g_lane
		if (g < NUM_TIMERS) begin : g_on
			optb_pkg::lane_cmd_t cmd;
			logic                sel;

			assign sel         = adv && (idx_s1 == 2'(g));
			assign cmd.tick    = adv && (kind_s1 == optb_pkg::KIND_TICK);
			assign cmd.start   = sel && (kind_s1 == optb_pkg::KIND_START);
			assign cmd.restart = sel && (kind_s1 == optb_pkg::KIND_RESTART);

			optb_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.cfg_wr   (cfg_valid &&
				           cfg_index == optb_pkg::REG_DELAY0 + optb_pkg::CFG_IDX_W'(g)),
				.cfg_data (cfg_data),
				.oneshot  (oneshot_q[g]),
				.expired  (exp_vec[g]),
				.err      (err_vec[g])
			);
		end else begin : g_off
			assign exp_vec[g] = 1'b0;
			assign err_vec[g] = optb_pkg::ERR_NONE;
		end
	end

	assign err_sel = err_vec[idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (kind_s1)
				optb_pkg::KIND_TICK: begin
					expired_q <= exp_vec;
					err_q     <= optb_pkg::ERR_NONE;
				end
				optb_pkg::KIND_START, optb_pkg::KIND_RESTART: begin
					expired_q <= '0;
					err_q     <= err_sel;
				end
				default: begin
					expired_q <= '0;
					err_q     <= optb_pkg::ERR_NONE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign expired_mask = expired_q;
	assign error_code   = err_q;

endmodule

[rtl/core/optb_checker.sv]
// ----------------------------------------------------------------------------
// optb_checker
// Port-level checks for the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module optb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] expired_mask,
	input logic [1:0] error_code
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(expired_mask) && $stable(error_code))
		else $error("result changed while stalled");

	// a result never carries both an expiry and an error
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired_mask != 4'd0 |-> error_code == optb_pkg::ERR_NONE)
		else $error("expiry and error in one item");

	// accepted item shows up as a result after the stage register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result missing after accept");

	// input only backs up behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

endmodule

bind oneshot_periodic_timer_bank_core optb_checker u_optb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.expired_mask (expired_mask),
	.error_code   (error_code)
);

[tb/oneshot_periodic_timer_bank_core_tb.sv]
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_bank_core_tb
// Self-checking bench for the timer bank. A directed opening covers error
// codes, one-shot and periodic expiry and delay changes on running timers.
// Random phases with fresh delays and modes follow. Every item is fed through
// a behavioral model of the four timers and each result is checked in order.
// The sender is bursty and the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank_core_tb;

	localparam int         NUM_TIMERS   = 4;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         DRAIN_CYCLES = 4;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         HOLD_CYCLES  = 60;
	localparam int         HOLD_AFTER   = 200;
	localparam int         PHASES       = 8;
	localparam int         PHASE_ITEMS  = 75;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] idx;
	} timer_cmd_t;

	typedef struct packed {
		logic [3:0] expired;
		logic [1:0] err;
	} timer_result_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [1:0]                     kind        = optb_pkg::KIND_TICK;
	logic [1:0]                     timer_index = '0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic [3:0]                     expired_mask;
	logic [1:0]                     error_code;
	logic                           cfg_valid   = 1'b0;
	logic                           cfg_ready;
	logic [optb_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
	logic [optb_pkg::DELAY_W-1:0]   cfg_data    = '0;

	// timer bank model
	logic [optb_pkg::DELAY_W-1:0]   timer_delay [NUM_TIMERS] = '{default: '0};
	logic [optb_pkg::ELAPSED_W-1:0] elapsed_ms  [NUM_TIMERS] = '{default: '0};
	logic [NUM_TIMERS-1:0]          oneshot = '1;
	logic [NUM_TIMERS-1:0]          running = '0;

	timer_cmd_t    cmd_queue[$];
	timer_result_t expected_results[$];

	int       mismatches   = 0;
	int       results_seen = 0;
	logic     in_took      = 1'b0;
	int       burst_left   = 1;
	int       gap_left     = 0;
	int       hold_left    = 0;
	bit       hold_done    = 1'b0;
	int       mode_left    = 0;
	rx_mode_t rx_mode      = RX_ALWAYS;
	int       idle_cycles  = 0;

	oneshot_periodic_timer_bank_core #(
		.NUM_TIMERS(NUM_TIMERS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.timer_index (timer_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.expired_mask(expired_mask),
		.error_code  (error_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial forever #1 clk = ~clk;

	function automatic timer_result_t predict_bank_step(timer_cmd_t c);
		timer_result_t r;
		r = '0;
		if (c.kind == optb_pkg::KIND_TICK) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (running[i]) begin
					if (elapsed_ms[i] != optb_pkg::ELAPSED_MAX)
						elapsed_ms[i]++;
					if (elapsed_ms[i] > {1'b0, timer_delay[i]}) begin
						r.expired[i] = 1'b1;
						elapsed_ms[i] = '0;
						if (oneshot[i])
							running[i] = 1'b0;
					end
				end
			end
		end else if ((c.kind == optb_pkg::KIND_START || c.kind == optb_pkg::KIND_RESTART) &&
				int'(c.idx) < NUM_TIMERS) begin
			if (timer_delay[c.idx] == '0) begin
				r.err = optb_pkg::ERR_NODELAY;
			end else if (running[c.idx] && c.kind == optb_pkg::KIND_START) begin
				r.err = optb_pkg::ERR_RUNNING;
			end else begin
				running[c.idx] = 1'b1;
				elapsed_ms[c.idx] = '0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic queue_cmd(logic [1:0] k, logic [1:0] idx);
		timer_cmd_t c;
		c.kind = k;
		c.idx = idx;
		cmd_queue.push_back(c);
	endtask

	// cfg_valid stays high across back-to-back writes; cfg_done lowers it
	task automatic cfg_write(logic [optb_pkg::CFG_IDX_W-1:0] idx,
			logic [optb_pkg::DELAY_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic cfg_done();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// monitor and model update
	always @(posedge clk) begin
		timer_result_t want;
		timer_cmd_t    c;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < optb_pkg::REG_ONESHOT)
					timer_delay[cfg_index[1:0]] = cfg_data;
				else if (cfg_index == optb_pkg::REG_ONESHOT)
					oneshot = cfg_data[NUM_TIMERS-1:0];
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item pending", 8'(expired_mask), 8'h0);
				end else begin
					want = expected_results.pop_front();
					if (expired_mask !== want.expired)
						report_mismatch("expired_mask", 8'(expired_mask), 8'(want.expired));
					if (error_code !== want.err)
						report_mismatch("error_code", 8'(error_code), 8'(want.err));
				end
			end
			if (in_valid && in_ready) begin
				c.kind = kind;
				c.idx = timer_index;
				expected_results.push_back(predict_bank_step(c));
			end
		end
	end

	// item driver: bursts with gaps
	always @(negedge clk) begin
		timer_cmd_t c;
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				c = cmd_queue.pop_front();
				in_valid <= 1'b1;
				kind <= c.kind;
				timer_index <= c.idx;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: changing stall patterns plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 64);
				end
				mode_left--;
				case (rx_mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL oneshot_periodic_timer_bank_core");
				$finish;
			end
		end
	end

	initial begin
		logic [optb_pkg::DELAY_W-1:0] d;
		logic [3:0]                   m;
		int                           r;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: every delay unset
		for (int t = 0; t < NUM_TIMERS; t++)
			queue_cmd(optb_pkg::KIND_START, 2'(t));
		queue_cmd(optb_pkg::KIND_RESTART, 2'd1);
		queue_cmd(optb_pkg::KIND_TICK, 2'd2);
		queue_cmd(KIND_UNUSED, 2'd3);
		drain();

		// timer 0 one-shot, 1 periodic, 2 one-shot max delay, 3 periodic
		cfg_write(optb_pkg::REG_DELAY0, 32'd1);
		cfg_write(optb_pkg::REG_DELAY0 + 3'd1, 32'd2);
		cfg_write(optb_pkg::REG_DELAY0 + 3'd2, 32'hFFFF_FFFF);
		cfg_write(optb_pkg::REG_DELAY0 + 3'd3, 32'd3);
		cfg_write(optb_pkg::REG_ONESHOT, 32'hFFFF_FFF5);
		cfg_write(optb_pkg::REG_ONESHOT + 3'd1, $urandom());
		cfg_write(optb_pkg::REG_ONESHOT + 3'd2, $urandom());
		cfg_write(optb_pkg::REG_ONESHOT + 3'd3, $urandom());
		cfg_done();
		for (int t = 0; t < NUM_TIMERS; t++)
			queue_cmd(optb_pkg::KIND_START, 2'(t));
		queue_cmd(optb_pkg::KIND_START, 2'd0);
		queue_cmd(optb_pkg::KIND_RESTART, 2'd1);
		repeat (4) queue_cmd(optb_pkg::KIND_TICK, 2'd3);
		queue_cmd(optb_pkg::KIND_START, 2'd0);
		queue_cmd(optb_pkg::KIND_RESTART, 2'd2);
		queue_cmd(KIND_UNUSED, 2'd0);
		drain();

		// delays changed under running timers
		cfg_write(optb_pkg::REG_DELAY0 + 3'd1, 32'd0);
		cfg_write(optb_pkg::REG_DELAY0 + 3'd2, 32'd1);
		cfg_done();
		queue_cmd(optb_pkg::KIND_TICK, 2'd0);
		queue_cmd(optb_pkg::KIND_TICK, 2'd1);
		queue_cmd(optb_pkg::KIND_RESTART, 2'd1);
		queue_cmd(optb_pkg::KIND_START, 2'd1);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				r = $urandom_range(0, 9);
				if (p == 0)
					d = '1;
				else if (p == 1)
					d = 32'd1;
				else if (r < 6)
					d = $urandom_range(1, 6);
				else if (r == 6)
					d = '0;
				else if (r == 7)
					d = $urandom();
				else if (r == 8)
					d = '1;
				else
					d = $urandom_range(7, 20);
				cfg_write(optb_pkg::REG_DELAY0 + optb_pkg::CFG_IDX_W'(t), d);
			end
			m = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : 4'($urandom_range(0, 15));
			cfg_write(optb_pkg::REG_ONESHOT, {28'($urandom()), m});
			if ($urandom_range(0, 1) == 1)
				cfg_write(optb_pkg::REG_ONESHOT +
					optb_pkg::CFG_IDX_W'($urandom_range(1, 3)), $urandom());
			cfg_done();
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					queue_cmd(optb_pkg::KIND_TICK, 2'($urandom_range(0, 3)));
				else if (r < 75)
					queue_cmd(optb_pkg::KIND_START, 2'($urandom_range(0, 3)));
				else if (r < 95)
					queue_cmd(optb_pkg::KIND_RESTART, 2'($urandom_range(0, 3)));
				else
					queue_cmd(KIND_UNUSED, 2'($urandom_range(0, 3)));
			end
			drain();
		end

		if (mismatches == 0)
			$display("PASS oneshot_periodic_timer_bank_core");
		else
			$display("FAIL oneshot_periodic_timer_bank_core");
		$finish;
	end

endmodule

[files.f]
rtl/core/optb_pkg.sv
rtl/core/optb_lane.sv
rtl/core/oneshot_periodic_timer_bank_core.sv
rtl/core/optb_checker.sv
tb/oneshot_periodic_timer_bank_core_tb.sv
